/* rtl/ndvi_pkg.sv */
// Shared types, constants and the palette table of the NDVI pixel classifier.
package ndvi_pkg;

    // Field widths.
    localparam int PIX_W   = 8;
    localparam int GAIN_W  = 24;
    localparam int OFFS_W  = 25;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 25;
    localparam int CLS_W   = 3;

    // Datapath widths: gain * pixel fits 32 bits, adding a signed offset needs 34,
    // the sum and difference of two reflectances 35, their negation 36, and five
    // times a normalised value 39 (40 with one guard bit on top).
    localparam int PROD_W = GAIN_W + PIX_W;
    localparam int REFL_W = PROD_W + 2;
    localparam int SUM_W  = REFL_W + 1;
    localparam int NORM_W = SUM_W + 1;
    localparam int CMP_W  = NORM_W + 4;

    // Pipeline stages.
    localparam int NUM_STAGES = 5;
    localparam int STG_MUL  = 0;
    localparam int STG_REFL = 1;
    localparam int STG_SUM  = 2;
    localparam int STG_NORM = 3;
    localparam int STG_OUT  = 4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_NIR_GAIN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NIR_OFFSET = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RED_GAIN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RED_OFFSET = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DARK_LEVEL = 3'd4;

    // Reset values of the configuration registers.
    localparam logic [GAIN_W-1:0]        NIR_GAIN_RST   = 24'd48184;
    localparam logic signed [OFFS_W-1:0] NIR_OFFSET_RST = -25'sd301705;
    localparam logic [GAIN_W-1:0]        RED_GAIN_RST   = 24'd21703;
    localparam logic signed [OFFS_W-1:0] RED_OFFSET_RST = -25'sd196260;
    localparam logic [PIX_W-1:0]         DARK_LEVEL_RST = 8'd5;

    typedef logic [CLS_W-1:0] cls_t;

    // Class codes.
    localparam cls_t CLS_HIGH_GREEN = 3'd0;
    localparam cls_t CLS_MED_GREEN  = 3'd1;
    localparam cls_t CLS_LOW_GREEN  = 3'd2;
    localparam cls_t CLS_YELLOW     = 3'd3;
    localparam cls_t CLS_BLUE       = 3'd4;
    localparam cls_t CLS_HIGH_BLUE  = 3'd5;
    localparam cls_t CLS_BLACK      = 3'd6;

    typedef struct packed {
        logic [PIX_W-1:0] blue;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] red;
    } colour_t;

    // Load strobes for each pipeline stage, driven by the handshake control.
    typedef struct packed {
        logic [NUM_STAGES-1:0] load;
    } pipe_ctl_t;

    // Side information that travels with each request.
    typedef struct packed {
        logic red_nz;
        logic eof;
    } side_t;

    function automatic colour_t palette(input cls_t cls);
        colour_t c;
        case (cls)
            CLS_HIGH_GREEN: c = '{blue: 8'd0,   green: 8'd207, red: 8'd35};
            CLS_MED_GREEN:  c = '{blue: 8'd0,   green: 8'd236, red: 8'd39};
            CLS_LOW_GREEN:  c = '{blue: 8'd74,  green: 8'd231, red: 8'd100};
            CLS_YELLOW:     c = '{blue: 8'd106, green: 8'd251, red: 8'd236};
            CLS_BLUE:       c = '{blue: 8'd252, green: 8'd69,  red: 8'd83};
            CLS_HIGH_BLUE:  c = '{blue: 8'd191, green: 8'd0,   red: 8'd14};
            default:        c = '{blue: 8'd0,   green: 8'd0,   red: 8'd0};
        endcase
        return c;
    endfunction

endpackage

/* rtl/ndvi_ctrl.sv */
// Valid/ready control of the classifier pipeline, with the side-information shift line.
module ndvi_ctrl
    import ndvi_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  side_t     in_side,
    output logic      out_valid,
    input  logic      out_ready,
    output pipe_ctl_t ctl,
    output side_t     side_norm,
    output side_t     side_out
);

    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] valid_next;
    logic [NUM_STAGES-1:0] rdy;
    side_t                 side_reg [NUM_STAGES];

    // A stage may load when it is empty or when the stage after it moves on,
    // so bubbles are squeezed out even while the output is stalled.
    always_comb
    begin
        rdy[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || out_ready;
        for (int k = NUM_STAGES - 2; k >= 0; k--)
        begin
            rdy[k] = !valid_reg[k] || rdy[k+1];
        end
    end

    always_comb
    begin
        valid_next[0] = rdy[0] ? in_valid : valid_reg[0];
        for (int k = 1; k < NUM_STAGES; k++)
        begin
            valid_next[k] = rdy[k] ? valid_reg[k-1] : valid_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            side_reg[0] <= in_side;
        end
        for (int k = 1; k < NUM_STAGES; k++)
        begin
            if (rdy[k])
            begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    assign ctl.load  = rdy;
    assign in_ready  = rdy[0];
    assign out_valid = valid_reg[NUM_STAGES-1];
    assign side_norm = side_reg[STG_NORM];
    assign side_out  = side_reg[STG_OUT];

endmodule

/* rtl/ndvi_refl.sv */
// Reflectance of one band: gain times pixel, then offset added unless the pixel is dark.
module ndvi_refl
    import ndvi_pkg::*;
(
    input  logic                      clk,
    input  pipe_ctl_t                 ctl,
    input  logic [PIX_W-1:0]          pix,
    input  logic [GAIN_W-1:0]         gain,
    input  logic signed [OFFS_W-1:0]  offset,
    input  logic [PIX_W-1:0]          dark_level,
    output logic signed [REFL_W-1:0]  refl
);

    logic [PROD_W-1:0]        prod_reg;
    logic                     dark_reg;
    logic signed [REFL_W-1:0] refl_reg;
    logic signed [REFL_W-1:0] refl_next;

    always_ff @(posedge clk)
    begin
        if (ctl.load[STG_MUL])
        begin
            prod_reg <= PROD_W'(gain) * PROD_W'(pix);
            dark_reg <= (pix < dark_level);
        end
    end

    always_comb
    begin
        if (dark_reg)
        begin
            refl_next = '0;
        end
        else
        begin
            refl_next = $signed({2'b00, prod_reg})
                      + REFL_W'(offset);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load[STG_REFL])
        begin
            refl_reg <= refl_next;
        end
    end

    assign refl = refl_reg;

endmodule

/* rtl/ndvi_class.sv */
// NDVI classing by cross-multiplied threshold compares, and palette lookup.
module ndvi_class
    import ndvi_pkg::*;
(
    input  logic                     clk,
    input  pipe_ctl_t                ctl,
    input  logic signed [REFL_W-1:0] nir_refl,
    input  logic signed [REFL_W-1:0] red_refl,
    input  logic                     red_nz,
    output cls_t                     cls_code,
    output colour_t                  colour
);

    logic signed [SUM_W-1:0]  diff_reg;
    logic signed [SUM_W-1:0]  sum_reg;
    logic signed [NORM_W-1:0] num_reg;
    logic signed [NORM_W-1:0] den_reg;
    logic                     zero_reg;
    logic signed [NORM_W-1:0] num_next;
    logic signed [NORM_W-1:0] den_next;
    logic signed [CMP_W-1:0]  num5;
    logic signed [CMP_W-1:0]  num2;
    logic signed [CMP_W-1:0]  den1;
    logic signed [CMP_W-1:0]  den3;
    logic signed [CMP_W-1:0]  den4;
    cls_t                     cls_next;
    cls_t                     cls_reg;
    colour_t                  colour_reg;

    // Difference and sum of the two reflectances.
    always_ff @(posedge clk)
    begin
        if (ctl.load[STG_SUM])
        begin
            diff_reg <= SUM_W'(nir_refl) - SUM_W'(red_refl);
            sum_reg  <= SUM_W'(nir_refl) + SUM_W'(red_refl);
        end
    end

    // Make the denominator non-negative so the compares need no sign cases.
    always_comb
    begin
        if (sum_reg[SUM_W-1])
        begin
            num_next = -NORM_W'(diff_reg);
            den_next = -NORM_W'(sum_reg);
        end
        else
        begin
            num_next = NORM_W'(diff_reg);
            den_next = NORM_W'(sum_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load[STG_NORM])
        begin
            num_reg  <= num_next;
            den_reg  <= den_next;
            zero_reg <= (sum_reg == '0);
        end
    end

    always_comb
    begin
        num5 = (CMP_W'(num_reg) <<< 2) + CMP_W'(num_reg);
        num2 = CMP_W'(num_reg) <<< 1;
        den1 = CMP_W'(den_reg);
        den3 = (CMP_W'(den_reg) <<< 1) + CMP_W'(den_reg);
        den4 = CMP_W'(den_reg) <<< 2;

        if (zero_reg)
        begin
            // Zero sum: the raw red byte is classed, which is either zero or above 0.8.
            cls_next = red_nz ? CLS_HIGH_GREEN : CLS_BLACK;
        end
        else if (num5 > den4)
        begin
            cls_next = CLS_HIGH_GREEN;
        end
        else if (num5 >= den3)
        begin
            cls_next = CLS_MED_GREEN;
        end
        else if (num5 >= den1)
        begin
            cls_next = CLS_LOW_GREEN;
        end
        else if (num_reg > 0)
        begin
            cls_next = CLS_YELLOW;
        end
        else if (num_reg == 0)
        begin
            cls_next = CLS_BLACK;
        end
        else if (num2 > -den1)
        begin
            cls_next = CLS_BLUE;
        end
        else
        begin
            cls_next = CLS_HIGH_BLUE;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load[STG_OUT])
        begin
            cls_reg    <= cls_next;
            colour_reg <= palette(cls_next);
        end
    end

    assign cls_code = cls_reg;
    assign colour   = colour_reg;

endmodule

/* rtl/ndvi_pixel_classifier_top.sv */
// Top level of the NDVI pixel classifier: configuration registers and pipeline.
//
// Usage: each request on the input channel (in_valid/in_ready) carries one pixel,
// a near-infrared byte and a red byte, plus an end-of-frame flag. Each pixel gives
// exactly one result on the output channel (out_valid/out_ready): a class code and
// its blue, green and red palette bytes, with the end-of-frame flag passed along.
// The pipeline has five register stages: multiply, offset and dark test, sum and
// difference, sign normalisation, threshold compare with palette lookup. A result
// is presented from the last of these stage registers, and one
// request is taken in every cycle as long as the receiver keeps out_ready high.
// When the receiver stalls, results wait in the pipeline registers and each stage
// still loads while a stage after it is empty, so up to five requests are held
// before in_ready falls; nothing is dropped or repeated.
// Reset empties the pipeline and sets the configuration registers to their
// default calibration. Registers are written through cfg_write/cfg_index/cfg_data
// in a single cycle and should only change while no pixel is in flight; writes to
// an index past the dark level are ignored.
module ndvi_pixel_classifier_top
    import ndvi_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [PIX_W-1:0]      nir_pixel,
    input  logic [PIX_W-1:0]      red_pixel,
    input  logic                  end_of_frame,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [PIX_W-1:0]      out_blue,
    output logic [PIX_W-1:0]      out_green,
    output logic [PIX_W-1:0]      out_red,
    output logic [CLS_W-1:0]      class_code,
    output logic                  frame_end
);

    logic [GAIN_W-1:0]        nir_gain_reg;
    logic signed [OFFS_W-1:0] nir_offset_reg;
    logic [GAIN_W-1:0]        red_gain_reg;
    logic signed [OFFS_W-1:0] red_offset_reg;
    logic [PIX_W-1:0]         dark_level_reg;

    pipe_ctl_t                ctl;
    side_t                    in_side;
    side_t                    side_norm;
    side_t                    side_out;
    logic signed [REFL_W-1:0] nir_refl;
    logic signed [REFL_W-1:0] red_refl;
    colour_t                  colour;
    cls_t                     cls_code;

    // Configuration registers; each keeps only its own width of the write data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nir_gain_reg   <= NIR_GAIN_RST;
            nir_offset_reg <= NIR_OFFSET_RST;
            red_gain_reg   <= RED_GAIN_RST;
            red_offset_reg <= RED_OFFSET_RST;
            dark_level_reg <= DARK_LEVEL_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_NIR_GAIN:   nir_gain_reg   <= cfg_data[GAIN_W-1:0];
                REG_NIR_OFFSET: nir_offset_reg <= $signed(cfg_data[OFFS_W-1:0]);
                REG_RED_GAIN:   red_gain_reg   <= cfg_data[GAIN_W-1:0];
                REG_RED_OFFSET: red_offset_reg <= $signed(cfg_data[OFFS_W-1:0]);
                REG_DARK_LEVEL: dark_level_reg <= cfg_data[PIX_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // The zero-sum case needs only whether the raw red byte is non-zero.
    assign in_side.red_nz = (red_pixel != '0);
    assign in_side.eof    = end_of_frame;

    ndvi_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_side   (in_side),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .ctl       (ctl),
        .side_norm (side_norm),
        .side_out  (side_out)
    );

    ndvi_refl u_nir_refl (
        .clk        (clk),
        .ctl        (ctl),
        .pix        (nir_pixel),
        .gain       (nir_gain_reg),
        .offset     (nir_offset_reg),
        .dark_level (dark_level_reg),
        .refl       (nir_refl)
    );

    ndvi_refl u_red_refl (
        .clk        (clk),
        .ctl        (ctl),
        .pix        (red_pixel),
        .gain       (red_gain_reg),
        .offset     (red_offset_reg),
        .dark_level (dark_level_reg),
        .refl       (red_refl)
    );

    ndvi_class u_class (
        .clk      (clk),
        .ctl      (ctl),
        .nir_refl (nir_refl),
        .red_refl (red_refl),
        .red_nz   (side_norm.red_nz),
        .cls_code (cls_code),
        .colour   (colour)
    );

    assign out_blue   = colour.blue;
    assign out_green  = colour.green;
    assign out_red    = colour.red;
    assign class_code = cls_code;
    assign frame_end  = side_out.eof;

endmodule

/* tb/sv/ndvi_scoreboard_pkg.sv */
// Scoreboard for the NDVI pixel classifier: calibration mirror, class prediction and checking.
package ndvi_scoreboard_pkg;

    import ndvi_pkg::*;

    typedef struct packed {
        cls_t    code;
        colour_t colour;
        logic    eof;
    } pixel_result_t;

    class pixel_class_scoreboard;

        logic [GAIN_W-1:0]        nir_gain;
        logic signed [OFFS_W-1:0] nir_offset;
        logic [GAIN_W-1:0]        red_gain;
        logic signed [OFFS_W-1:0] red_offset;
        logic [PIX_W-1:0]         dark_level;

        colour_t       shade [CLS_HIGH_GREEN:CLS_BLACK];
        pixel_result_t expected_colours [$];
        int            mismatches;

        function new();
            nir_gain   = NIR_GAIN_RST;
            nir_offset = NIR_OFFSET_RST;
            red_gain   = RED_GAIN_RST;
            red_offset = RED_OFFSET_RST;
            dark_level = DARK_LEVEL_RST;
            mismatches = 0;
            shade[CLS_HIGH_GREEN] = '{blue: 8'd0,   green: 8'd207, red: 8'd35};
            shade[CLS_MED_GREEN]  = '{blue: 8'd0,   green: 8'd236, red: 8'd39};
            shade[CLS_LOW_GREEN]  = '{blue: 8'd74,  green: 8'd231, red: 8'd100};
            shade[CLS_YELLOW]     = '{blue: 8'd106, green: 8'd251, red: 8'd236};
            shade[CLS_BLUE]       = '{blue: 8'd252, green: 8'd69,  red: 8'd83};
            shade[CLS_HIGH_BLUE]  = '{blue: 8'd191, green: 8'd0,   red: 8'd14};
            shade[CLS_BLACK]      = '{blue: 8'd0,   green: 8'd0,   red: 8'd0};
        endfunction

        // Only the width of each register is kept; unknown indexes change nothing.
        function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_NIR_GAIN:   nir_gain   = data[GAIN_W-1:0];
                REG_NIR_OFFSET: nir_offset = data[OFFS_W-1:0];
                REG_RED_GAIN:   red_gain   = data[GAIN_W-1:0];
                REG_RED_OFFSET: red_offset = data[OFFS_W-1:0];
                REG_DARK_LEVEL: dark_level = data[PIX_W-1:0];
                default: ;
            endcase
        endfunction

        function longint reflectance_of(logic [PIX_W-1:0] pix, logic [GAIN_W-1:0] gain,
                                        logic signed [OFFS_W-1:0] offs);
            if (pix < dark_level)
                return 0;
            return longint'(gain) * longint'(pix) + longint'(offs);
        endfunction

        // Exact cross-multiplied comparison of num/den against the class thresholds.
        function cls_t ratio_class(longint num, longint den);
            if (den < 0)
            begin
                num = -num;
                den = -den;
            end
            if (5 * num > 4 * den)
                return CLS_HIGH_GREEN;
            if (5 * num >= 3 * den)
                return CLS_MED_GREEN;
            if (5 * num >= den)
                return CLS_LOW_GREEN;
            if (num > 0)
                return CLS_YELLOW;
            if (num == 0)
                return CLS_BLACK;
            if (2 * num > -den)
                return CLS_BLUE;
            return CLS_HIGH_BLUE;
        endfunction

        function void note_request(logic [PIX_W-1:0] nir, logic [PIX_W-1:0] red, logic eof);
            longint        a;
            longint        b;
            pixel_result_t r;
            a = reflectance_of(nir, nir_gain, nir_offset);
            b = reflectance_of(red, red_gain, red_offset);
            if (a + b != 0)
                r.code = ratio_class(a - b, a + b);
            else
                r.code = (red != '0) ? CLS_HIGH_GREEN : CLS_BLACK;
            r.colour = shade[r.code];
            r.eof    = eof;
            expected_colours.push_back(r);
        endfunction

        function int pending();
            return expected_colours.size();
        endfunction

        task report_mismatch(string note);
            $display("%0t: mismatch: %s", $time, note);
            mismatches++;
        endtask

        task check_result(pixel_result_t seen);
            pixel_result_t want;
            if (expected_colours.size() == 0)
            begin
                report_mismatch($sformatf("result with no pixel outstanding, class %0d",
                                          seen.code));
            end
            else
            begin
                want = expected_colours.pop_front();
                if (seen.code !== want.code)
                    report_mismatch($sformatf("class_code %0d, expected %0d",
                                              seen.code, want.code));
                if (seen.colour.blue !== want.colour.blue)
                    report_mismatch($sformatf("out_blue %0d, expected %0d",
                                              seen.colour.blue, want.colour.blue));
                if (seen.colour.green !== want.colour.green)
                    report_mismatch($sformatf("out_green %0d, expected %0d",
                                              seen.colour.green, want.colour.green));
                if (seen.colour.red !== want.colour.red)
                    report_mismatch($sformatf("out_red %0d, expected %0d",
                                              seen.colour.red, want.colour.red));
                if (seen.eof !== want.eof)
                    report_mismatch($sformatf("frame_end %0b, expected %0b",
                                              seen.eof, want.eof));
            end
        endtask

    endclass

endpackage

/* tb/sv/tb_ndvi_pixel_classifier_top.sv */
// Self-checking testbench of the NDVI pixel classifier top level.
module tb_ndvi_pixel_classifier_top;

    import ndvi_pkg::*;
    import ndvi_scoreboard_pkg::*;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_ready;
    logic [PIX_W-1:0]      nir_pixel;
    logic [PIX_W-1:0]      red_pixel;
    logic                  end_of_frame;
    logic                  out_valid;
    logic                  out_ready;
    logic [PIX_W-1:0]      out_blue;
    logic [PIX_W-1:0]      out_green;
    logic [PIX_W-1:0]      out_red;
    logic [CLS_W-1:0]      class_code;
    logic                  frame_end;

    // Idle rates in percent for the sender and the receiver, and the length of a
    // forced receiver hold-off, all set by the main sequence.
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int stall_left    = 0;

    pixel_class_scoreboard classes = new();

    ndvi_pixel_classifier_top uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .nir_pixel    (nir_pixel),
        .red_pixel    (red_pixel),
        .end_of_frame (end_of_frame),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_blue     (out_blue),
        .out_green    (out_green),
        .out_red      (out_red),
        .class_code   (class_code),
        .frame_end    (frame_end)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Receiver. Each cycle out_ready is drawn afresh from the current idle rate,
    // unless a hold-off is running; the hold-off is counted down here so that
    // the sender carries on offering requests while the pipeline fills behind it.
    initial
    begin
        forever
        begin
            if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
            @(posedge clk);
        end
    end

    // Both channels are sampled at the rising edge, where every driven input still
    // holds the value that the block saw, since all drives use nonblocking updates.
    // An accepted request is turned into its expected colour straight away, with
    // the calibration that is in force at that moment.
    always @(posedge clk)
    begin
        pixel_result_t seen;
        if (rst_n && in_valid && in_ready)
            classes.note_request(nir_pixel, red_pixel, end_of_frame);
        if (rst_n && out_valid && out_ready)
        begin
            seen.code         = class_code;
            seen.colour.blue  = out_blue;
            seen.colour.green = out_green;
            seen.colour.red   = out_red;
            seen.eof          = frame_end;
            classes.check_result(seen);
        end
    end

    // Offers one request, after a random number of idle cycles, and returns at the
    // edge where it is taken. in_valid is left high so that back-to-back requests
    // keep it high without a dip.
    task automatic send_pixel(input logic [PIX_W-1:0] nir, input logic [PIX_W-1:0] red,
                              input logic eof);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        nir_pixel    <= nir;
        red_pixel    <= red;
        end_of_frame <= eof;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // Stops offering requests and waits until every expected result has been
    // collected, then lets the pipeline drain for its full depth. It first waits
    // for an edge so that a request taken at the current edge has already been noted.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (classes.pending() != 0)
            @(posedge clk);
        repeat (NUM_STAGES) @(posedge clk);
    endtask

    // Writes a full calibration set once the block is idle, followed by a write to
    // an unused index, which the block must ignore. Values are passed at the full
    // port width so that bits above a register's width are exercised too.
    task automatic write_config(input logic [CFG_DATA_W-1:0] nir_g,
                                input logic [CFG_DATA_W-1:0] nir_o,
                                input logic [CFG_DATA_W-1:0] red_g,
                                input logic [CFG_DATA_W-1:0] red_o,
                                input logic [CFG_DATA_W-1:0] dark);
        logic [CFG_IDX_W-1:0]  reg_sel   [6];
        logic [CFG_DATA_W-1:0] reg_value [6];
        settle();
        reg_sel   = '{REG_NIR_GAIN, REG_NIR_OFFSET, REG_RED_GAIN, REG_RED_OFFSET,
                      REG_DARK_LEVEL,
                      CFG_IDX_W'(REG_DARK_LEVEL + 1 + $urandom_range(2))};
        reg_value = '{nir_g, nir_o, red_g, red_o, dark, CFG_DATA_W'($urandom())};
        for (int i = 0; i < 6; i++)
        begin
            cfg_write <= 1'b1;
            cfg_index <= reg_sel[i];
            cfg_data  <= reg_value[i];
            @(posedge clk);
            classes.write_register(reg_sel[i], reg_value[i]);
        end
        cfg_write <= 1'b0;
    endtask

    // Pixel bytes: half are uniform, a quarter are small so that exact ratios and
    // threshold hits are frequent, and a quarter sit one below, at or one above the dark level.
    function automatic logic [PIX_W-1:0] pick_pixel();
        int v;
        case ($urandom_range(3))
            0, 1:    v = $urandom_range(255);
            2:       v = $urandom_range(12);
            default: v = int'(classes.dark_level) - 1 + int'($urandom_range(2));
        endcase
        if (v < 0)
            v = 0;
        if (v > 255)
            v = 255;
        return v[PIX_W-1:0];
    endfunction

    initial
    begin
        rst_n        <= 1'b0;
        cfg_write    <= 1'b0;
        cfg_index    <= REG_NIR_GAIN;
        cfg_data     <= '0;
        in_valid     <= 1'b0;
        nir_pixel    <= '0;
        red_pixel    <= '0;
        end_of_frame <= 1'b0;
        send_idle_pct = 14;
        recv_idle_pct = 72;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Default calibration. Pixels below the dark level in both bands give a
        // zero sum, so the raw red byte decides: zero gives black, anything else
        // the top green class. The byte extremes follow.
        send_pixel(8'd0, 8'd0, 1'b0);
        send_pixel(8'd3, 8'd4, 1'b0);
        send_pixel(8'd255, 8'd255, 1'b1);
        send_pixel(8'd255, 8'd0, 1'b0);
        send_pixel(8'd0, 8'd255, 1'b0);
        send_pixel(8'd5, 8'd5, 1'b0);

        // Unit gains, no offset and no dark level make the reflectances equal to
        // the bytes, so each threshold can be hit exactly: 0.8, 0.6, 0.2, zero
        // and -0.5, with a pixel strictly inside every class but the middle green one.
        write_config(25'd1, '0, 25'd1, '0, '0);
        send_pixel(8'd1, 8'd0, 1'b0);
        send_pixel(8'd9, 8'd1, 1'b0);
        send_pixel(8'd4, 8'd1, 1'b0);
        send_pixel(8'd2, 8'd1, 1'b0);
        send_pixel(8'd3, 8'd2, 1'b0);
        send_pixel(8'd11, 8'd9, 1'b0);
        send_pixel(8'd7, 8'd7, 1'b0);
        send_pixel(8'd3, 8'd4, 1'b0);
        send_pixel(8'd1, 8'd3, 1'b0);
        send_pixel(8'd0, 8'd5, 1'b0);
        send_pixel(8'd0, 8'd0, 1'b1);

        // A negative near-infrared offset makes reflectances negative: the ratio
        // leaves the range -1 to 1, and the sum can cancel to zero with a
        // non-zero red byte.
        write_config(25'd1, -25'sd200, 25'd1, '0, '0);
        send_pixel(8'd0, 8'd100, 1'b0);
        send_pixel(8'd150, 8'd100, 1'b0);
        send_pixel(8'd100, 8'd100, 1'b0);
        send_pixel(8'd200, 8'd0, 1'b1);

        // Random traffic across six calibrations, two for each idling pattern:
        // sender mostly busy and receiver mostly idle, then the reverse, then no
        // idling at all. The last pattern also carries a long receiver hold-off.
        for (int setting = 0; setting < 6; setting++)
        begin
            case (setting / 2)
                0:
                begin
                    send_idle_pct = 14;
                    recv_idle_pct = 72;
                end
                1:
                begin
                    send_idle_pct = 72;
                    recv_idle_pct = 14;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            case (setting)
                0: write_config(CFG_DATA_W'(NIR_GAIN_RST), CFG_DATA_W'(NIR_OFFSET_RST),
                                CFG_DATA_W'(RED_GAIN_RST), CFG_DATA_W'(RED_OFFSET_RST),
                                CFG_DATA_W'(DARK_LEVEL_RST));
                // One band at the largest gain and the other at zero, with the most negative and
                // the largest offsets; the first gain value carries an extra top bit that must be dropped.
                1: write_config(25'h1FFFFFF, 25'h1000000, '0, 25'h0FFFFFF, 25'd255);
                2: write_config('0, 25'h0FFFFFF, 25'h0FFFFFF, 25'h1000000, '0);
                3: write_config(25'($urandom_range(3, 1)),
                                25'(int'($urandom_range(600)) - 300),
                                25'($urandom_range(3, 1)),
                                25'(int'($urandom_range(600)) - 300),
                                25'($urandom_range(8)));
                4: write_config(25'($urandom()), 25'($urandom()), 25'($urandom()),
                                25'($urandom()), 25'($urandom()));
                default: write_config(25'd1, '0, 25'd1, '0, '0);
            endcase
            if (setting == 4)
                stall_left = 80;
            repeat (84)
                send_pixel(pick_pixel(), pick_pixel(), $urandom_range(15) == 0);
        end

        settle();
        repeat (NUM_STAGES + 4) @(posedge clk);
        if (classes.pending() != 0)
            classes.report_mismatch($sformatf("%0d results never arrived", classes.pending()));
        if (classes.mismatches == 0)
            $display("ndvi_pixel_classifier_top regression: pass");
        else
            $display("ndvi_pixel_classifier_top regression: fail");
        $finish;
    end

    // Watchdog: the slowest correct run needs well under a tenth of this.
    initial
    begin
        #(2_000_000);
        $display("ndvi_pixel_classifier_top regression: fail");
        $finish;
    end

endmodule

/* ndvi_pixel_classifier_top.f */
rtl/ndvi_pkg.sv
rtl/ndvi_ctrl.sv
rtl/ndvi_refl.sv
rtl/ndvi_class.sv
rtl/ndvi_pixel_classifier_top.sv
tb/sv/ndvi_scoreboard_pkg.sv
tb/sv/tb_ndvi_pixel_classifier_top.sv
